// ===== rtl/core/ipav_pkg.sv =====
// Shared types, constants and helpers for the IP address text validator.
`default_nettype none

package ipav_pkg;

	localparam int MAX_V6_LENGTH_DEF = 45;

	localparam int TEXT_W   = 8;
	localparam int KIND_W   = 2;
	localparam int OCTET_W  = 10;
	localparam int GROUP_W  = 4;
	localparam int RUN_W    = 3;
	localparam int ODIG_W   = 3;
	localparam int DOTS_W   = 2;
	localparam int GSUM_W   = 5;

	localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [TEXT_W-1:0] CH_NINE  = 8'h39;
	localparam logic [TEXT_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [TEXT_W-1:0] CH_LO_F  = 8'h66;
	localparam logic [TEXT_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [TEXT_W-1:0] CH_UP_F  = 8'h46;
	localparam logic [TEXT_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [TEXT_W-1:0] CH_COLON = 8'h3a;

	localparam logic [GROUP_W-1:0] GROUP_SAT   = 4'd15;
	localparam logic [RUN_W-1:0]   RUN_SAT     = 3'd5;
	localparam logic [RUN_W-1:0]   RUN_MAX     = 3'd4;
	localparam logic [ODIG_W-1:0]  ODIG_SAT    = 3'd4;
	localparam logic [ODIG_W-1:0]  ODIG_MAX    = 3'd3;
	localparam logic [DOTS_W-1:0]  DOTS_MAX    = 2'd3;
	localparam logic [OCTET_W-1:0] OCTET_MAX   = 10'd255;
	localparam logic [GSUM_W-1:0]  V6_GROUPS   = 5'd8;

	typedef enum logic [KIND_W-1:0] {
		KIND_INVALID = 2'd0,
		KIND_IPV4    = 2'd1,
		KIND_IPV6    = 2'd2
	} kind_t;

	function automatic logic octet_ok(
		input logic [OCTET_W-1:0] value,
		input logic [ODIG_W-1:0]  digits,
		input logic               lead_zero
	);
		logic ok;
		ok = (digits != '0) && (digits <= ODIG_MAX);
		if (lead_zero && (digits > 3'd1))
			ok = 1'b0;
		if (value > OCTET_MAX)
			ok = 1'b0;
		return ok;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ipav_scan.sv =====
// Per-character scanner state and end-of-string classification.
`default_nettype none

module ipav_scan import ipav_pkg::*; #(
	parameter int MAX_V6_LENGTH = MAX_V6_LENGTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [TEXT_W-1:0] text_byte,
	input  wire logic              final_byte,
	output kind_t                  kind
);

	localparam int CW = $clog2(MAX_V6_LENGTH + 2);
	localparam logic [CW-1:0] CHAR_SAT = CW'(MAX_V6_LENGTH + 1);
	localparam logic [CW-1:0] CHAR_MAX = CW'(MAX_V6_LENGTH);

	logic [CW-1:0]      char_q, char_n;
	logic [GROUP_W-1:0] group_q, group_n;
	logic               dcolon_q, dcolon_n;
	logic [RUN_W-1:0]   run_q, run_n;
	logic [OCTET_W-1:0] oval_q, oval_n;
	logic [ODIG_W-1:0]  odig_q, odig_n;
	logic               ozero_q, ozero_n;
	logic [DOTS_W-1:0]  dots_q, dots_n;
	logic               nondec_q, nondec_n;
	logic               colon_q, colon_n;
	logic               prevc_q, prevc_n;
	logic               fail_q, fail_n;

	logic               is_num, is_hexl, is_dot, is_colon;
	logic               colon_pair;
	logic [3:0]         dval;
	logic [GSUM_W-1:0]  groups;
	logic               v6_ok, quad_ok;
	logic [RUN_W-1:0]   run_inc;

	always_comb begin
		is_num   = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
		is_hexl  = ((text_byte >= CH_LO_A) && (text_byte <= CH_LO_F)) ||
		           ((text_byte >= CH_UP_A) && (text_byte <= CH_UP_F));
		is_dot   = (text_byte == CH_DOT);
		is_colon = (text_byte == CH_COLON);
		dval     = text_byte[3:0];
		run_inc  = (run_q < RUN_SAT) ? run_q + 3'd1 : run_q;
	end

	always_comb begin
		char_n     = char_q;
		group_n    = group_q;
		dcolon_n   = dcolon_q;
		run_n      = run_q;
		oval_n     = oval_q;
		odig_n     = odig_q;
		ozero_n    = ozero_q;
		dots_n     = dots_q;
		nondec_n   = nondec_q;
		colon_n    = colon_q;
		prevc_n    = 1'b0;
		fail_n     = fail_q;
		colon_pair = 1'b0;

		// a leading single colon must be followed by a second one
		if (prevc_q && (char_q == CW'(1)) && !is_colon)
			fail_n = 1'b1;

		if (is_num) begin
			run_n = run_inc;
			if (odig_q == '0)
				ozero_n = (dval == 4'd0);
			if (odig_q < ODIG_MAX)
				oval_n = (oval_q << 3) + (oval_q << 1) + OCTET_W'(dval);
			if (odig_q < ODIG_SAT)
				odig_n = odig_q + 3'd1;
		end else if (is_hexl) begin
			if (dots_q != '0)
				fail_n = 1'b1;
			nondec_n = 1'b1;
			run_n    = run_inc;
		end else if (is_dot) begin
			if (nondec_q || !octet_ok(oval_q, odig_q, ozero_q) || (dots_q == DOTS_MAX))
				fail_n = 1'b1;
			else
				dots_n = dots_q + 2'd1;
			oval_n  = '0;
			odig_n  = '0;
			ozero_n = 1'b0;
			run_n   = '0;
		end else if (is_colon) begin
			if (dots_q != '0)
				fail_n = 1'b1;
			if (prevc_q) begin
				if (dcolon_q)
					fail_n = 1'b1;
				dcolon_n   = 1'b1;
				colon_pair = 1'b1;
			end else if (char_q != '0) begin
				if ((run_q == '0) || (run_q > RUN_MAX))
					fail_n = 1'b1;
				if (group_q != GROUP_SAT)
					group_n = group_q + 4'd1;
			end
			colon_n  = 1'b1;
			oval_n   = '0;
			odig_n   = '0;
			ozero_n  = 1'b0;
			run_n    = '0;
			dots_n   = '0;
			nondec_n = 1'b0;
			prevc_n  = 1'b1;
		end else begin
			fail_n = 1'b1;
		end

		if (char_q < CHAR_SAT)
			char_n = char_q + CW'(1);
	end

	always_comb begin
		kind    = KIND_INVALID;
		quad_ok = (dots_n == DOTS_MAX) && !nondec_n && octet_ok(oval_n, odig_n, ozero_n);
		groups  = GSUM_W'(group_n);
		v6_ok   = (char_n <= CHAR_MAX);
		if (is_colon && !colon_pair)
			v6_ok = 1'b0;
		if (dots_n != '0) begin
			if (quad_ok)
				groups = groups + 5'd2;
			else
				v6_ok = 1'b0;
		end else if (run_n != '0) begin
			if (run_n > RUN_MAX)
				v6_ok = 1'b0;
			groups = groups + 5'd1;
		end
		if (!fail_n) begin
			if (!colon_n) begin
				if (quad_ok)
					kind = KIND_IPV4;
			end else if (v6_ok) begin
				if (dcolon_n ? (groups < V6_GROUPS) : (groups == V6_GROUPS))
					kind = KIND_IPV6;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q   <= '0;
			group_q  <= '0;
			dcolon_q <= 1'b0;
			run_q    <= '0;
			oval_q   <= '0;
			odig_q   <= '0;
			ozero_q  <= 1'b0;
			dots_q   <= '0;
			nondec_q <= 1'b0;
			colon_q  <= 1'b0;
			prevc_q  <= 1'b0;
			fail_q   <= 1'b0;
		end else if (step) begin
			if (final_byte) begin
				char_q   <= '0;
				group_q  <= '0;
				dcolon_q <= 1'b0;
				run_q    <= '0;
				oval_q   <= '0;
				odig_q   <= '0;
				ozero_q  <= 1'b0;
				dots_q   <= '0;
				nondec_q <= 1'b0;
				colon_q  <= 1'b0;
				prevc_q  <= 1'b0;
				fail_q   <= 1'b0;
			end else begin
				char_q   <= char_n;
				group_q  <= group_n;
				dcolon_q <= dcolon_n;
				run_q    <= run_n;
				oval_q   <= oval_n;
				odig_q   <= odig_n;
				ozero_q  <= ozero_n;
				dots_q   <= dots_n;
				nondec_q <= nondec_n;
				colon_q  <= colon_n;
				prevc_q  <= prevc_n;
				fail_q   <= fail_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ip_address_text_validator.sv =====
// Top level of the IP address text validator: input stage, scanner, result register.
// One character per request on the input stream, tlast on the final character.
// Each character is registered, then classified combinationally by the scanner,
// so the block takes a new character every clock unless stalled as below; a final
// character's result passes through the input register and the result register.
// A result (0 invalid, 1 IPv4, 2 IPv6) is issued only for the final character of
// each string and waits in the result register while further characters keep
// flowing, stalling input only when a second result would overwrite one untaken.
`default_nettype none

module ip_address_text_validator import ipav_pkg::*; #(
	parameter int MAX_V6_LENGTH = MAX_V6_LENGTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
	input  wire logic       s_axis_tlast,   // final_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata    // [1:0] address_kind, [7:2] zero
);

	logic              valid_s1;
	logic [TEXT_W-1:0] byte_s1;
	logic              last_s1;
	logic              advance;
	logic              out_valid_q;
	kind_t             kind_q;
	kind_t             kind;

	always_comb begin
		advance       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
		s_axis_tready = !valid_s1 || advance;
		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = {6'd0, kind_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	ipav_scan #(
		.MAX_V6_LENGTH(MAX_V6_LENGTH)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.text_byte  (byte_s1),
		.final_byte (last_s1),
		.kind       (kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= KIND_INVALID;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
			kind_q      <= kind;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_ip_address_text_validator.sv =====
// Self-checking testbench for ip_address_text_validator: directed and random address strings.
`default_nettype none

module tb_ip_address_text_validator;
	import ipav_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int V6_TEXT_MAX    = MAX_V6_LENGTH_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 8;

	class kind_tracker;
		kind_t       pending[$];
		int          errors;
		int          n_v4;
		int          n_v6;
		int          n_bad;
		logic [5:0]  chars;
		logic [3:0]  groups_done;
		logic        dc_seen;
		logic [2:0]  run_len;
		logic [9:0]  oct_val;
		logic [2:0]  oct_digits;
		logic        oct_lz;
		logic [1:0]  dots;
		logic        seg_hex;
		logic        colon_any;
		logic        prev_colon;
		logic        broken;

		function new();
			clear_string();
		endfunction

		function void clear_octet();
			oct_val    = '0;
			oct_digits = '0;
			oct_lz     = 1'b0;
		endfunction

		function void clear_segment();
			clear_octet();
			run_len = '0;
			dots    = '0;
			seg_hex = 1'b0;
		endfunction

		function void clear_string();
			chars       = '0;
			groups_done = '0;
			dc_seen     = 1'b0;
			colon_any   = 1'b0;
			prev_colon  = 1'b0;
			broken      = 1'b0;
			clear_segment();
		endfunction

		function bit octet_good();
			if (oct_digits < 1 || oct_digits > 3)
				return 0;
			if (oct_lz && oct_digits > 1)
				return 0;
			return oct_val <= OCTET_MAX;
		endfunction

		function bit quad_good();
			return dots == 2'd3 && !seg_hex && octet_good();
		endfunction

		function void bump_run();
			if (run_len < 3'd5)
				run_len++;
		endfunction

		function void note_request(logic [7:0] c, logic last);
			int    pos;
			bit    pair;
			int    groups;
			bit    ok;
			kind_t kind;
			pos  = chars;
			pair = 0;
			kind = KIND_INVALID;
			if (prev_colon && pos == 1 && c != CH_COLON)
				broken = 1'b1;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				bump_run();
				if (oct_digits == 0)
					oct_lz = (c == CH_ZERO);
				if (oct_digits < 3)
					oct_val = oct_val * 10 + (c - CH_ZERO);
				if (oct_digits < 4)
					oct_digits++;
				prev_colon = 1'b0;
			end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
				if (dots > 0)
					broken = 1'b1;
				seg_hex = 1'b1;
				bump_run();
				prev_colon = 1'b0;
			end else if (c == CH_DOT) begin
				if (seg_hex || !octet_good() || dots >= 2'd3)
					broken = 1'b1;
				else
					dots++;
				clear_octet();
				run_len    = '0;
				prev_colon = 1'b0;
			end else if (c == CH_COLON) begin
				if (dots > 0)
					broken = 1'b1;
				if (prev_colon) begin
					if (dc_seen)
						broken = 1'b1;
					dc_seen = 1'b1;
					pair    = 1;
				end else if (pos != 0) begin
					if (run_len == 0 || run_len > 4)
						broken = 1'b1;
					if (groups_done < 4'd15)
						groups_done++;
				end
				colon_any = 1'b1;
				clear_segment();
				prev_colon = 1'b1;
			end else begin
				broken     = 1'b1;
				prev_colon = 1'b0;
			end
			if (chars < V6_TEXT_MAX + 1)
				chars++;
			if (!last)
				return;
			if (!broken) begin
				if (!colon_any) begin
					if (quad_good())
						kind = KIND_IPV4;
				end else begin
					groups = groups_done;
					ok     = chars <= V6_TEXT_MAX;
					if (c == CH_COLON && !pair)
						ok = 0;
					if (dots > 0) begin
						if (quad_good())
							groups += 2;
						else
							ok = 0;
					end else if (run_len > 0) begin
						if (run_len > 4)
							ok = 0;
						groups += 1;
					end
					if (ok && (dc_seen ? (groups < 8) : (groups == 8)))
						kind = KIND_IPV6;
				end
			end
			case (kind)
				KIND_IPV4: n_v4++;
				KIND_IPV6: n_v6++;
				default:   n_bad++;
			endcase
			pending = {pending, kind};
			clear_string();
		endfunction

		function void check_result(logic [7:0] data);
			kind_t want;
			if (pending.size() == 0) begin
				$error("address_kind: no result expected, actual %0d", data[1:0]);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[1:0] !== want) begin
				$error("address_kind mismatch: expected %0d, actual %0d", want, data[1:0]);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;

	kind_tracker scb = new();
	int tx_idle;
	int rx_idle;
	int hold_left;
	int stall_cycles;
	int bytes_sent;

	ip_address_text_validator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// receiver: random back-pressure, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				scb.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request accepted for %0d cycles", stall_cycles);
				$display("ip_address_text_validator regression: fail");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		scb.note_request(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_char();
		string set;
		set = "0123456789abcdefABCDEF.:.:gG/ %";
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	task automatic send_noise();
		int n;
		bit any_byte;
		n        = $urandom_range(1, 60);
		any_byte = $urandom_range(0, 1);
		for (int i = 0; i < n; i++)
			send_byte(any_byte ? 8'($urandom_range(0, 255)) : pick_char(), i == n - 1);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (scb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic string octet_text(bit sloppy);
		if (sloppy) begin
			case ($urandom_range(0, 3))
				0:       return $sformatf("0%0d", $urandom_range(0, 99));
				1:       return $sformatf("%0d", $urandom_range(256, 999));
				2:       return $sformatf("%0d", $urandom_range(1000, 9999));
				default: return "";
			endcase
		end
		case ($urandom_range(0, 3))
			0:       return $sformatf("%0d", $urandom_range(0, 9));
			1:       return $sformatf("%0d", $urandom_range(10, 99));
			2:       return $sformatf("%0d", $urandom_range(100, 255));
			default: return $sformatf("%0d", $urandom_range(0, 255));
		endcase
	endfunction

	function automatic string v4_text();
		string s;
		bit sloppy;
		sloppy = ($urandom_range(0, 9) == 0);
		s = octet_text(0);
		for (int i = 1; i < 4; i++)
			s = {s, ".", octet_text(sloppy && $urandom_range(0, 2) == 0)};
		return s;
	endfunction

	function automatic string hex_group();
		string set;
		string s;
		set = "0123456789abcdefABCDEF";
		s = "";
		repeat ($urandom_range(1, 4))
			s = $sformatf("%s%c", s, set[$urandom_range(0, set.len() - 1)]);
		return s;
	endfunction

	function automatic string join_groups(string parts[$], int lo, int hi);
		string s;
		s = "";
		for (int i = lo; i < hi; i++)
			s = (i == lo) ? parts[i] : {s, ":", parts[i]};
		return s;
	endfunction

	function automatic string v6_text();
		string parts[$];
		bit dc;
		bit quad;
		int slots;
		int p;
		dc    = $urandom_range(0, 1);
		slots = dc ? $urandom_range(0, 7) : 8;
		quad  = ($urandom_range(0, 3) == 0) && slots >= 2;
		for (int i = 0; i < (quad ? slots - 2 : slots); i++)
			parts = {parts, hex_group()};
		if (quad)
			parts = {parts, v4_text()};
		if (!dc)
			return join_groups(parts, 0, parts.size());
		p = $urandom_range(0, quad ? parts.size() - 1 : parts.size());
		return {join_groups(parts, 0, p), "::", join_groups(parts, p, parts.size())};
	endfunction

	function automatic string mutate(string s);
		int i;
		i = $urandom_range(0, s.len() - 1);
		case ($urandom_range(0, 4))
			0: s[i] = pick_char();
			1: s = {s.substr(0, i - 1), $sformatf("%c", pick_char()), s.substr(i, s.len() - 1)};
			2: if (s.len() > 1) s = {s.substr(0, i - 1), s.substr(i + 1, s.len() - 1)};
			3: s = {s, ":", hex_group(), ":", hex_group()};
			default: s[i] = 8'($urandom_range(1, 255));
		endcase
		return s;
	endfunction

	task automatic random_strings(int budget);
		int start;
		int r;
		string s;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				send_text(v4_text());
			end else if (r < 70) begin
				send_text(v6_text());
			end else if (r < 90) begin
				s = $urandom_range(0, 1) ? v4_text() : v6_text();
				s = mutate(s);
				if ($urandom_range(0, 3) == 0)
					s = mutate(s);
				send_text(s);
			end else begin
				send_noise();
			end
		end
	endtask

	string directed[$] = '{
		"0.0.0.0", "255.255.255.255", "256.1.1.1", "01.2.3.4", "1.2.3.1000",
		"1.2.3", "1.2.3.4.5", "1.2.3.4.", "1.2.3.4a", "g.1.2.3",
		"::", "::1", ":1::2", "1::", "1:2:3:4:5:6:7:",
		"1:::2", "1::2::3", "1.2.3.4::1", "::ffff:1.2.3.4",
		"ABCD:ef01:2345:6789:abcd:EF01:2345:6789", "1:2:3:4:5:6:7",
		"0000:0000:0000:0000:0000:0000:255.255.255.255",
		"0000:0000:0000:0000:0000:0000:0000:0000:0000:0000", "12345::1", "1.2.3.\377"
	};

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		hold_left     = 0;
		stall_cycles  = 0;
		bytes_sent    = 0;
		tx_idle       = 21;
		rx_idle       = 87;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_text(directed[i]);

		// every short string yields a result: fills the output side while it is held
		hold_left = 300;
		repeat (40)
			send_text($sformatf("%0d", $urandom_range(0, 9)));
		drain();

		random_strings(390);
		drain();

		tx_idle = 87;
		rx_idle = 21;
		random_strings(390);
		drain();

		tx_idle = 0;
		rx_idle = 0;
		random_strings(390);
		drain();

		$display("covered %0d characters in %0d strings: %0d IPv4, %0d IPv6, %0d invalid",
			bytes_sent, scb.n_v4 + scb.n_v6 + scb.n_bad, scb.n_v4, scb.n_v6, scb.n_bad);
		$display("with directed corner cases, a long output hold-off and three idle profiles");
		if (scb.errors == 0)
			$display("ip_address_text_validator regression: pass");
		else
			$display("ip_address_text_validator regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== ip_address_text_validator.f =====
rtl/core/ipav_pkg.sv
rtl/core/ipav_scan.sv
rtl/core/ip_address_text_validator.sv
test/tb_ip_address_text_validator.sv
